// ----- src/ipv6ehs_pkg.sv -----
`timescale 1ns / 1ps

package ipv6ehs_pkg;

  // Status codes of a result beat
  localparam logic [1:0] ST_FOUND = 2'd0;
  localparam logic [1:0] ST_NONE  = 2'd1;
  localparam logic [1:0] ST_TRUNC = 2'd2;
  localparam logic [1:0] ST_ESP   = 2'd3;

  // Next-header protocol numbers
  localparam logic [7:0] NH_HOPOPT   = 8'd0;
  localparam logic [7:0] NH_ROUTING  = 8'd43;
  localparam logic [7:0] NH_FRAGMENT = 8'd44;
  localparam logic [7:0] NH_ESP      = 8'd50;
  localparam logic [7:0] NH_AUTH     = 8'd51;
  localparam logic [7:0] NH_NONE     = 8'd59;
  localparam logic [7:0] NH_DSTOPTS  = 8'd60;

  localparam int unsigned REM_BITS = 11;

  typedef struct packed {
    logic       first;
    logic [7:0] initial_next;
    logic       byte_valid;
    logic [7:0] data_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  protocol;
    logic [15:0] offset;
  } out_item_t;

  typedef struct packed {
    logic       decided;
    logic [1:0] status;
  } verdict_t;

  function automatic logic is_skippable(logic [7:0] nh);
    return (nh == NH_HOPOPT) || (nh == NH_ROUTING) || (nh == NH_FRAGMENT) ||
           (nh == NH_AUTH) || (nh == NH_DSTOPTS);
  endfunction

  // Verdict on a header type met at the start of a header
  function automatic verdict_t examine(logic [7:0] nh);
    verdict_t v;
    v.decided = 1'b0;
    v.status  = ST_FOUND;
    if (!is_skippable(nh)) begin
      v.decided = 1'b1;
      if (nh == NH_NONE) begin
        v.status = ST_NONE;
      end else if (nh == NH_ESP) begin
        v.status = ST_ESP;
      end
    end
    return v;
  endfunction

endpackage

// ----- src/ipv6ehs_in_stage.sv -----
`timescale 1ns / 1ps

module ipv6ehs_in_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ipv6ehs_pkg::in_item_t in_data_i,
  input  logic                 step_i,
  output logic                 item_vld_o,
  output ipv6ehs_pkg::in_item_t item_o
);
  import ipv6ehs_pkg::*;

  logic     vld_q, vld_d;
  in_item_t item_q;

  // Hold the beat while the walker cannot take it
  assign in_stall_o = vld_q && !step_i;
  assign vld_d      = in_stall_o ? vld_q : in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      item_q <= in_data_i;
    end
  end

  assign item_vld_o = vld_q;
  assign item_o     = item_q;

endmodule

// ----- src/ipv6ehs_walker.sv -----
`timescale 1ns / 1ps

module ipv6ehs_walker #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  ipv6ehs_pkg::in_item_t  item_i,
  output ipv6ehs_pkg::out_item_t result_o
);
  import ipv6ehs_pkg::*;

  typedef enum logic [1:0] {
    PH_START,
    PH_LEN,
    PH_BODY
  } phase_e;

  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

  phase_e                 phase_q, phase_d;
  logic [7:0]             cur_q, cur_d;
  logic [7:0]             pend_q, pend_d;
  logic [REM_BITS-1:0]    rem_q, rem_d;
  logic [OFFSET_BITS-1:0] cons_q, cons_d;
  logic                   dec_q, dec_d;
  logic [1:0]             dst_q, dst_d;
  verdict_t               vstart, vnext;

  assign vstart = examine(item_i.initial_next);
  // The body phase is never reached on a first beat, so the held byte is current
  assign vnext  = examine(pend_q);

  always_comb begin
    phase_d = phase_q;
    cur_d   = cur_q;
    pend_d  = pend_q;
    rem_d   = rem_q;
    cons_d  = cons_q;
    dec_d   = dec_q;
    dst_d   = dst_q;

    // A first beat restarts the walk before its byte is taken
    if (item_i.first) begin
      phase_d = PH_START;
      cur_d   = item_i.initial_next;
      pend_d  = 8'd0;
      rem_d   = '0;
      cons_d  = '0;
      dec_d   = vstart.decided;
      dst_d   = vstart.status;
    end

    if (item_i.byte_valid && !dec_d) begin
      if (cons_d != OFFSET_MAX) begin
        cons_d = cons_d + 1'b1;
      end
      unique case (phase_d)
        PH_START: begin
          pend_d  = item_i.data_byte;
          phase_d = PH_LEN;
        end
        PH_LEN: begin
          // (len + 1) * 8 minus the two bytes already taken
          rem_d   = {item_i.data_byte, 3'b110};
          phase_d = PH_BODY;
        end
        default: begin
          if (rem_d != '0) begin
            rem_d = rem_d - 1'b1;
          end
          if (rem_d == '0) begin
            cur_d   = pend_d;
            phase_d = PH_START;
            dec_d   = vnext.decided;
            dst_d   = vnext.status;
          end
        end
      endcase
    end
  end

  always_comb begin
    result_o = '0;
    if (dec_d && (dst_d == ST_FOUND)) begin
      result_o.status   = ST_FOUND;
      result_o.protocol = cur_d;
      result_o.offset   = 16'(cons_d);
    end else begin
      result_o.status = dec_d ? dst_d : ST_TRUNC;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      cur_q   <= 8'd0;
      pend_q  <= 8'd0;
      rem_q   <= '0;
      cons_q  <= '0;
      dec_q   <= 1'b0;
      dst_q   <= ST_FOUND;
    end else if (step_i) begin
      phase_q <= phase_d;
      cur_q   <= cur_d;
      pend_q  <= pend_d;
      rem_q   <= rem_d;
      cons_q  <= cons_d;
      dec_q   <= dec_d;
      dst_q   <= dst_d;
    end
  end

endmodule

// ----- src/ipv6ehs_out_stage.sv -----
`timescale 1ns / 1ps

module ipv6ehs_out_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  ipv6ehs_pkg::out_item_t result_i,
  output logic                  free_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output ipv6ehs_pkg::out_item_t out_data_o
);
  import ipv6ehs_pkg::*;

  logic      vld_q, vld_d;
  out_item_t data_q;

  // Register can take a new result when empty or being drained
  assign free_o = !vld_q || !out_stall_i;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (!out_stall_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = data_q;

endmodule

// ----- src/ipv6_ext_header_skipper_unit.sv -----
`timescale 1ns / 1ps
// Channel | Handshake                  | Beat
// in      | in_valid_i / in_stall_o    | in_data_i  (first, initial_next, byte_valid, data_byte, last)
// out     | out_valid_o / out_stall_i  | out_data_o (status, protocol, offset)
//
// One beat per cycle sustained while the result register is not stalled; an accepted beat
// is held in the input register, then passes through the walker logic into the result register.
// Reset clears the walk state, which then acts as a region starting at hop-by-hop.
// Only beats marked last produce a result; the rest just advance the walk.
// A stalled result register holds the walker, which backs up into in_stall_o.

module ipv6_ext_header_skipper_unit #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  ipv6ehs_pkg::in_item_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output ipv6ehs_pkg::out_item_t out_data_o
);
  import ipv6ehs_pkg::*;

  logic      item_vld;
  in_item_t  item;
  out_item_t result;
  logic      out_free;
  logic      step;

  // Advance one beat when it is present and the result register has room
  assign step = item_vld && out_free;

  ipv6ehs_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .step_i     (step),
    .item_vld_o (item_vld),
    .item_o     (item)
  );

  ipv6ehs_walker #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_walker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (item),
    .result_o (result)
  );

  ipv6ehs_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step && item.last),
    .result_i    (result),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
